[rtl/fcba_pkg.sv]
// fcba_pkg: shared constants, register codes and the control struct of the
// five channel block averager. No dependencies.
`timescale 1ns / 1ps

package fcba_pkg;

    localparam int CHAN_NUM     = 5;
    localparam int SAMPLE_W     = 12;
    localparam int GAIN_W       = 16;
    localparam int GAIN_FRAC    = 12;
    localparam int AVG_W        = 16;
    localparam int BATT_CHAN    = 3;
    localparam int SPB_DEFAULT  = 8;

    localparam int IN_DATA_W    = 64;
    localparam int OUT_DATA_W   = CHAN_NUM * AVG_W;

    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 16;

    localparam logic [SAMPLE_W-1:0] THRESH_RESET = 12'd1600;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 8'd0,
        REG_GAIN      = 8'd1
    } t_reg_idx;

    typedef struct packed {
        logic valid;
        logic done;
        logic active;
    } t_ctrl;

endpackage

[rtl/fcba_lane.sv]
// fcba_lane: one channel - accumulator, divide by block length via reciprocal
// multiply with one correction step, then Q4.12 gain. Depends on fcba_pkg.
`timescale 1ns / 1ps

module fcba_lane import fcba_pkg::*; #(
    parameter int SAMPLES_PER_BLOCK = SPB_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_acc_en,
    input  logic                i_done,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [GAIN_W-1:0]   i_gain,
    output logic [AVG_W-1:0]    o_scaled
);

    localparam int SW = $clog2(SAMPLES_PER_BLOCK * ((1 << SAMPLE_W) - 1) + 1);
    localparam int QW = SAMPLE_W;
    localparam int PW = SAMPLE_W + GAIN_W;
    localparam logic [SW-1:0] NC    = SW'(SAMPLES_PER_BLOCK);
    localparam logic [SW-1:0] RECIP = SW'((2 ** SW) / SAMPLES_PER_BLOCK);

    logic [SW-1:0]   r_acc;
    logic [SW-1:0]   r_sum1;
    logic [SW-1:0]   r_sum2;
    logic [QW-1:0]   r_q0;
    logic [QW-1:0]   r_q;
    logic [PW-1:0]   r_prod;

    logic [SW-1:0]   n_acc;
    logic [2*SW-1:0] n_recip;
    logic [2*SW-1:0] n_qn;
    logic [SW-1:0]   n_rem;
    logic [QW-1:0]   n_q;

    assign n_acc   = r_acc + SW'(i_sample);
    // estimate is exact or one low
    assign n_recip = {{SW{1'b0}}, r_sum1} * {{SW{1'b0}}, RECIP};
    assign n_qn    = {{(2*SW-QW){1'b0}}, r_q0} * {{SW{1'b0}}, NC};
    assign n_rem   = r_sum2 - n_qn[SW-1:0];
    assign n_q     = (n_rem >= NC) ? QW'(r_q0 + 1'b1) : r_q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_acc_en) begin
            r_acc <= i_done ? '0 : n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum1 <= n_acc;
            r_sum2 <= r_sum1;
            r_q0   <= QW'(n_recip[2*SW-1:SW]);
            r_q    <= n_q;
            r_prod <= {{GAIN_W{1'b0}}, r_q} * {{QW{1'b0}}, i_gain};
        end
    end

    // 12b x 16b >> 12 never exceeds 16 bits
    assign o_scaled = r_prod[PW-1:GAIN_FRAC];

endmodule

[rtl/fcba_ctrl.sv]
// fcba_ctrl: block counter, battery threshold check and the control pipeline
// that runs alongside the lanes. Depends on fcba_pkg.
`timescale 1ns / 1ps

module fcba_ctrl import fcba_pkg::*; #(
    parameter int SAMPLES_PER_BLOCK = SPB_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_accept,
    input  logic [SAMPLE_W-1:0] i_battery,
    input  logic [SAMPLE_W-1:0] i_threshold,
    output logic                o_done,
    output t_ctrl               o_ctrl
);

    localparam int CW     = $clog2(SAMPLES_PER_BLOCK);
    localparam int STAGES = 4;

    logic [CW-1:0] r_count;
    t_ctrl         r_stage [STAGES];
    t_ctrl         n_head;

    assign o_done = (r_count == CW'(SAMPLES_PER_BLOCK - 1));

    always_comb begin
        n_head.valid  = i_accept;
        n_head.done   = o_done;
        n_head.active = (i_battery >= i_threshold);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= o_done ? '0 : CW'(r_count + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STAGES; s++) begin
                r_stage[s] <= '0;
            end
        end else if (i_en) begin
            r_stage[0] <= n_head;
            for (int s = 1; s < STAGES; s++) begin
                r_stage[s] <= r_stage[s-1];
            end
        end
    end

    assign o_ctrl = r_stage[STAGES-1];

endmodule

[rtl/five_channel_block_averager.sv]
// five_channel_block_averager: top level - config registers, five lanes,
// control pipeline and output merge register. Depends on fcba_pkg,
// fcba_lane, fcba_ctrl.
//
// channel  | dir | request when          | payload
// s_axis   | in  | tvalid & tready       | tdata: five 12b samples
// m_axis   | out | tvalid & tready       | tdata: five 16b averages, tlast, tuser
// cfg      | in  | cfg_valid & cfg_ready | index, data
//
// One request per cycle sustained while s_axis_tready is high; each result passes
// through accumulate, reciprocal multiply, correction, gain multiply, output reg.
// s_axis_tready falls only while the output register holds an untaken result.
// Synchronous active-low reset clears accumulators, counter and valids.
`timescale 1ns / 1ps

module five_channel_block_averager import fcba_pkg::*; #(
    parameter int SAMPLES_PER_BLOCK = SPB_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // air_pressure, fuel, accel, battery, coolant (12b each), 4b pad
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,

    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // avg_air_pressure, avg_fuel, avg_accel, avg_battery, avg_coolant (16b each)
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // block_done
    output logic                  o_m_axis_tlast,
    // device_active
    output logic                  o_m_axis_tuser,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [SAMPLE_W-1:0]   r_threshold;
    logic [GAIN_W-1:0]     r_gain;

    logic                  r_out_valid;
    logic                  r_out_last;
    logic                  r_out_user;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_DATA_W-1:0] n_out_data;

    logic                  w_en;
    logic                  w_accept;
    logic                  w_done;
    t_ctrl                 w_ctrl;
    logic [AVG_W-1:0]      w_scaled [CHAN_NUM];

    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && w_en;
    assign o_s_axis_tready = w_en;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
            r_gain      <= GAIN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_THRESHOLD: r_threshold <= i_cfg_data[SAMPLE_W-1:0];
                REG_GAIN:      r_gain      <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    fcba_ctrl #(
        .SAMPLES_PER_BLOCK (SAMPLES_PER_BLOCK)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_accept    (w_accept),
        .i_battery   (i_s_axis_tdata[BATT_CHAN*SAMPLE_W +: SAMPLE_W]),
        .i_threshold (r_threshold),
        .o_done      (w_done),
        .o_ctrl      (w_ctrl)
    );

    for (genvar c = 0; c < CHAN_NUM; c++) begin : g_lane
        fcba_lane #(
            .SAMPLES_PER_BLOCK (SAMPLES_PER_BLOCK)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_acc_en (w_accept),
            .i_done   (w_done),
            .i_sample (i_s_axis_tdata[c*SAMPLE_W +: SAMPLE_W]),
            .i_gain   (r_gain),
            .o_scaled (w_scaled[c])
        );
    end

    always_comb begin
        for (int c = 0; c < CHAN_NUM; c++) begin
            n_out_data[c*AVG_W +: AVG_W] = w_ctrl.done ? w_scaled[c] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_last <= w_ctrl.done;
            r_out_user <= w_ctrl.active;
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_user;

endmodule
